// ===== rtl/arsma_pkg.sv =====
// Shared constants, types and register codes for the axis reduction block.
package arsma_pkg;

    localparam int ACC_W           = 48;
    localparam int POS_W           = 16;
    localparam int SLOT_W          = 26;
    localparam int CFG_W           = 17;
    localparam int INNER_COUNT_W   = 11;
    localparam int DEF_INNER_DEPTH = 1024;
    localparam int DEF_VALUE_WIDTH = 32;

    typedef enum logic [1:0] {
        REG_REDUCE_MODE   = 2'd0,
        REG_OUTER_COUNT   = 2'd1,
        REG_REDUCED_COUNT = 2'd2,
        REG_INNER_COUNT   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic              seed;
        logic              emit;
        logic              last;
        logic [POS_W-1:0]  rpos;
        logic [SLOT_W-1:0] slot;
    } issue_t;

endpackage

// ===== rtl/arsma_if.sv =====
// Valid/ready channel interfaces for tensor elements and reduction results.
interface arsma_elem_if
    import arsma_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] elem_value;

    modport source (output valid, output elem_value, input ready);
    modport sink (input valid, input elem_value, output ready);
endinterface

interface arsma_result_if
    import arsma_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [ACC_W-1:0]  result_value;
    logic [POS_W-1:0]         result_index;
    logic [SLOT_W-1:0]        out_slot;
    logic                     tensor_last;

    modport source (output valid, output result_value, output result_index,
                    output out_slot, output tensor_last, input ready);
    modport sink (input valid, input result_value, input result_index,
                  input out_slot, input tensor_last, output ready);
endinterface

// ===== rtl/arsma_ctrl.sv =====
// Configuration registers and position counters that address the slot memory.
module arsma_ctrl
    import arsma_pkg::*;
#(
    parameter int INNER_DEPTH = DEF_INNER_DEPTH,
    localparam int IDX_W = (INNER_DEPTH > 1) ? $clog2(INNER_DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             accept,
    output logic             reduce_mode,
    output logic [IDX_W-1:0] addr,
    output issue_t           issue
);

    logic              mode_reg, mode_next;
    logic [POS_W-1:0]  outer_m1_reg, outer_m1_next;
    logic [POS_W-1:0]  reduced_m1_reg, reduced_m1_next;
    logic [IDX_W-1:0]  inner_m1_reg, inner_m1_next;
    logic [IDX_W-1:0]  inner_pos_reg, inner_pos_next;
    logic [POS_W-1:0]  reduced_pos_reg, reduced_pos_next;
    logic [POS_W-1:0]  outer_pos_reg, outer_pos_next;
    logic [SLOT_W-1:0] slot_base_reg, slot_base_next;

    logic [POS_W-1:0]         axis_m1_cfg;
    logic [IDX_W-1:0]         inner_m1_cfg;
    logic [INNER_COUNT_W-1:0] inner_raw;
    logic                     inner_last, reduced_last, outer_last;

    assign inner_raw = cfg_data[INNER_COUNT_W-1:0];

    always_comb
    begin
        if (cfg_data == '0)
        begin
            axis_m1_cfg = '0;
        end
        else if (cfg_data[CFG_W-1])
        begin
            axis_m1_cfg = '1;
        end
        else
        begin
            axis_m1_cfg = cfg_data[POS_W-1:0] - 1'b1;
        end

        if (inner_raw == '0)
        begin
            inner_m1_cfg = '0;
        end
        else if (32'(inner_raw) >= 32'(INNER_DEPTH))
        begin
            inner_m1_cfg = IDX_W'(INNER_DEPTH - 1);
        end
        else
        begin
            inner_m1_cfg = IDX_W'(inner_raw - 1'b1);
        end
    end

    assign inner_last   = (inner_pos_reg == inner_m1_reg);
    assign reduced_last = (reduced_pos_reg == reduced_m1_reg);
    assign outer_last   = (outer_pos_reg == outer_m1_reg);

    always_comb
    begin
        mode_next        = mode_reg;
        outer_m1_next    = outer_m1_reg;
        reduced_m1_next  = reduced_m1_reg;
        inner_m1_next    = inner_m1_reg;
        inner_pos_next   = inner_pos_reg;
        reduced_pos_next = reduced_pos_reg;
        outer_pos_next   = outer_pos_reg;
        slot_base_next   = slot_base_reg;

        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_REDUCE_MODE:   mode_next       = cfg_data[0];
                REG_OUTER_COUNT:   outer_m1_next   = axis_m1_cfg;
                REG_REDUCED_COUNT: reduced_m1_next = axis_m1_cfg;
                REG_INNER_COUNT:   inner_m1_next   = inner_m1_cfg;
                default:           mode_next       = mode_reg;
            endcase
            inner_pos_next   = '0;
            reduced_pos_next = '0;
            outer_pos_next   = '0;
            slot_base_next   = '0;
        end
        else if (accept)
        begin
            if (!inner_last)
            begin
                inner_pos_next = inner_pos_reg + 1'b1;
            end
            else
            begin
                inner_pos_next = '0;
                if (!reduced_last)
                begin
                    reduced_pos_next = reduced_pos_reg + 1'b1;
                end
                else
                begin
                    reduced_pos_next = '0;
                    if (!outer_last)
                    begin
                        outer_pos_next = outer_pos_reg + 1'b1;
                        slot_base_next = slot_base_reg + SLOT_W'(inner_m1_reg)
                                         + SLOT_W'(1);
                    end
                    else
                    begin
                        outer_pos_next = '0;
                        slot_base_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            outer_m1_reg    <= '0;
            reduced_m1_reg  <= '0;
            inner_m1_reg    <= '0;
            inner_pos_reg   <= '0;
            reduced_pos_reg <= '0;
            outer_pos_reg   <= '0;
            slot_base_reg   <= '0;
        end
        else
        begin
            mode_reg        <= mode_next;
            outer_m1_reg    <= outer_m1_next;
            reduced_m1_reg  <= reduced_m1_next;
            inner_m1_reg    <= inner_m1_next;
            inner_pos_reg   <= inner_pos_next;
            reduced_pos_reg <= reduced_pos_next;
            outer_pos_reg   <= outer_pos_next;
            slot_base_reg   <= slot_base_next;
        end
    end

    assign reduce_mode = mode_reg;
    assign addr        = inner_pos_reg;
    assign issue.seed  = (reduced_pos_reg == '0);
    assign issue.emit  = reduced_last;
    assign issue.last  = reduced_last && outer_last && inner_last;
    assign issue.rpos  = reduced_pos_reg;
    assign issue.slot  = slot_base_reg + SLOT_W'(inner_pos_reg);

    a_inner_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        inner_pos_reg <= inner_m1_reg)
        else $error("inner position beyond inner count");

    a_reduced_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        reduced_pos_reg <= reduced_m1_reg)
        else $error("reduced position beyond reduced count");

    a_wrap_clears_base: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cfg_we && issue.last |=> slot_base_reg == '0 && inner_pos_reg == '0)
        else $error("tensor end did not restart slot numbering");

endmodule

// ===== rtl/arsma_datapath.sv =====
// Slot memory with read-modify-write, forwarding and the result register.
module arsma_datapath
    import arsma_pkg::*;
#(
    parameter int INNER_DEPTH = DEF_INNER_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    localparam int IDX_W = (INNER_DEPTH > 1) ? $clog2(INNER_DEPTH) : 1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [IDX_W-1:0]              addr,
    input  issue_t                        issue,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic                          reduce_mode,
    output logic                          in_ready,
    arsma_result_if.source                result
);

    localparam int WORD_W = ACC_W + POS_W;

    logic [WORD_W-1:0] mem [INNER_DEPTH];

    logic                          s1_valid_reg;
    issue_t                        s1_issue_reg;
    logic [IDX_W-1:0]              s1_addr_reg;
    logic signed [VALUE_WIDTH-1:0] s1_value_reg;
    logic [WORD_W-1:0]             rd_data_reg;
    logic                          fwd_reg;
    logic [WORD_W-1:0]             fwd_data_reg;

    logic                          out_valid_reg;
    logic signed [ACC_W-1:0]       out_value_reg;
    logic [POS_W-1:0]              out_index_reg;
    logic [SLOT_W-1:0]             out_slot_reg;
    logic                          out_last_reg;

    logic                    s1_go;
    logic [WORD_W-1:0]       op_word;
    logic signed [ACC_W-1:0] op_acc;
    logic signed [ACC_W-1:0] v_ext;
    logic signed [ACC_W-1:0] new_acc;
    logic [POS_W-1:0]        new_idx;

    assign s1_go    = s1_valid_reg
                      && (!s1_issue_reg.emit || !out_valid_reg || result.ready);
    assign in_ready = !s1_valid_reg || s1_go;

    assign op_word = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign op_acc  = op_word[ACC_W-1:0];
    assign v_ext   = ACC_W'(s1_value_reg);

    always_comb
    begin
        new_acc = op_acc;
        new_idx = op_word[WORD_W-1:ACC_W];
        if (s1_issue_reg.seed)
        begin
            new_acc = v_ext;
            new_idx = '0;
        end
        else if (!reduce_mode)
        begin
            new_acc = op_acc + v_ext;
        end
        else if (v_ext > op_acc)
        begin
            new_acc = v_ext;
            new_idx = s1_issue_reg.rpos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            mem[s1_addr_reg] <= {new_idx, new_acc};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg  <= mem[addr];
            s1_issue_reg <= issue;
            s1_addr_reg  <= addr;
            s1_value_reg <= value;
        end
        if (s1_go)
        begin
            fwd_data_reg <= {new_idx, new_acc};
        end
        if (s1_go && s1_issue_reg.emit)
        begin
            out_value_reg <= new_acc;
            out_index_reg <= reduce_mode ? new_idx : '0;
            out_slot_reg  <= s1_issue_reg.slot;
            out_last_reg  <= s1_issue_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= s1_go && (s1_addr_reg == addr);
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
                fwd_reg      <= 1'b0;
            end
            out_valid_reg <= (s1_go && s1_issue_reg.emit)
                             || (out_valid_reg && !result.ready);
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.result_value = out_value_reg;
    assign result.result_index = out_index_reg;
    assign result.out_slot     = out_slot_reg;
    assign result.tensor_last  = out_last_reg;

    a_fwd_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> s1_valid_reg)
        else $error("forwarding flag set with empty stage");

    a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s1_go && s1_addr_reg == addr |=> fwd_reg)
        else $error("back-to-back access to one slot not forwarded");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_addr_reg))
        else $error("stalled stage lost its item");

endmodule

// ===== rtl/axis_reduce_sum_max_argmax.sv =====
// Top level of the tensor axis reduction: sum, or maximum with its index.
//
// Elements enter on elem, one per transfer, in row-major order (outer,
// reduced, inner). Software writes reduce_mode, outer_count, reduced_count
// and inner_count through cfg_we/cfg_index/cfg_data while the block is idle;
// any write restarts the tensor at position zero.
// Each element makes one read-modify-write of its inner slot in the slot
// memory (one read port, one write port). A new element is taken every
// cycle, also when consecutive elements hit the same slot, unless a stalled
// result holds the memory stage. A slot's last reduced element passes the
// memory stage and then the result register; tensor_last marks the final slot.
// While result is stalled, elements that do not complete a slot keep flowing;
// the next one that does is held in the memory stage and elem is held off
// until the pending result is taken.
// Reset clears the counters and sets mode sum, all counts one; the slot
// memory is not cleared, since every slot is seeded by its first element.
module axis_reduce_sum_max_argmax
    import arsma_pkg::*;
#(
    parameter int INNER_DEPTH = DEF_INNER_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    arsma_elem_if.sink       elem,
    arsma_result_if.source   result
);

    localparam int IDX_W = (INNER_DEPTH > 1) ? $clog2(INNER_DEPTH) : 1;

    logic             accept;
    logic             reduce_mode;
    logic [IDX_W-1:0] addr;
    issue_t           issue;
    logic             in_ready;

    assign accept     = elem.valid && in_ready;
    assign elem.ready = in_ready;

    arsma_ctrl #(
        .INNER_DEPTH (INNER_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .reduce_mode (reduce_mode),
        .addr        (addr),
        .issue       (issue)
    );

    arsma_datapath #(
        .INNER_DEPTH (INNER_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .addr        (addr),
        .issue       (issue),
        .value       (elem.elem_value),
        .reduce_mode (reduce_mode),
        .in_ready    (in_ready),
        .result      (result)
    );

endmodule
